// ----- rtl/core/tvs_pkg.sv -----
// Shared widths, codes and helpers for the trilinear volume sampler.
// Used by every module under rtl/core; depends on nothing else.
package tvs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF    = 32;
  localparam int VOXEL_BITS_DEF = 16;

  // Fixed field widths of the channels
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W   = 15;
  localparam int VALUE_W   = 16;
  localparam int POS_W     = 17;
  localparam int OUT_W     = 16;

  // Coordinate math: a voxel coordinate never exceeds the largest dim register value
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = CFG_W;
  localparam int ROW_W   = 2 * CFG_W;
  localparam int LIN_W   = 3 * CFG_W;
  localparam int AXIS_W  = 2 * IDX_W + FRAC_W;
  localparam int SPLIT_W = 3 * AXIS_W;

  localparam int ROUND_HALF = 32768;
  localparam int Q_DEPTH    = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(32);
  localparam logic [POS_W-1:0] ONE_Q16   = POS_W'(65536);

  // Opcodes of an input item
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = CFG_IDX_W'(2);

  // Status of the back end, watched at the top level
  typedef struct packed {
    logic busy;
    logic done;
  } bk_stat_t;

  function automatic int addr_width(input int max_dim);
    return $clog2(max_dim * max_dim * max_dim);
  endfunction

  function automatic int cmd_width(input int max_dim, input int voxel_bits);
    return 1 + addr_width(max_dim) + voxel_bits + SPLIT_W;
  endfunction

endpackage

// ----- rtl/core/trilinear_volume_sampler.sv -----
// Trilinear volume sampler: voxel store plus interpolating read-out.
// Top level; instantiates tvs_front, tvs_queue and tvs_back, depends on tvs_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 writes in_voxel_value at
//   in_voxel_index (x fastest) and gives no result; opcode 1 samples the volume
//   at the Q1.16 position in_pos_x/y/z and gives one result on the out channel.
//   Configuration (cfg_we, cfg_index, cfg_wdata) sets dim_x, dim_y, dim_z and is
//   to be written only while the block is idle; the block does not enforce this.
//   Throughput: one write per cycle while the back end is idle; a sample holds
//   the back end through the eight reads of the single-port voxel memory and the
//   shared blend multiplier before it takes the next item. An accepted write
//   passes the front register and the queue before it is written to memory.
//   A two-entry queue lets writes and samples be accepted while a sample runs.
//   Reset: dimension registers return to 32, queue and sequencer empty; voxel
//   contents are not cleared and read as unknown until written.
//   Out stall: the result register holds; the back end finishes its current
//   sample and waits, and the input keeps taking items until the queue fills.
module trilinear_volume_sampler #(
  parameter int MAX_DIM    = tvs_pkg::MAX_DIM_DEF,
  parameter int VOXEL_BITS = tvs_pkg::VOXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [tvs_pkg::INDEX_W-1:0]   in_voxel_index,
  input  logic [tvs_pkg::VALUE_W-1:0]   in_voxel_value,
  input  logic [tvs_pkg::POS_W-1:0]     in_pos_x,
  input  logic [tvs_pkg::POS_W-1:0]     in_pos_y,
  input  logic [tvs_pkg::POS_W-1:0]     in_pos_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tvs_pkg::OUT_W-1:0]     out_sample_value,
  input  logic                          cfg_we,
  input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvs_pkg::CFG_W-1:0]     cfg_wdata
);
  import tvs_pkg::*;

  localparam int CMD_W = cmd_width(MAX_DIM, VOXEL_BITS);

  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_in_data, q_out_data;
  logic [CFG_W-1:0] dim_x_eff, dim_y_eff;
  bk_stat_t         bk_stat;

  tvs_front #(
    .MAX_DIM    (MAX_DIM),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_voxel_index (in_voxel_index),
    .in_voxel_value (in_voxel_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .dim_x_eff      (dim_x_eff),
    .dim_y_eff      (dim_y_eff),
    .q_push         (q_push),
    .q_data         (q_in_data),
    .q_full         (q_full)
  );

  tvs_queue #(
    .WIDTH (CMD_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out_data),
    .empty     (q_empty)
  );

  tvs_back #(
    .MAX_DIM    (MAX_DIM),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_empty),
    .q_data           (q_out_data),
    .q_pop            (q_pop),
    .dim_x_eff        (dim_x_eff),
    .dim_y_eff        (dim_y_eff),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .bk_stat          (bk_stat)
  );

`ifndef SYNTHESIS
  // Never take an item out of an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A finished sample lands in the result register
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.done |=> out_valid)
    else $error("finished sample did not reach the result register");

  // A new result appears only after the back end ran a sample
  a_out_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result appeared without a sample");
`endif

endmodule

// ----- rtl/core/tvs_queue.sv -----
// Short command queue between the front and back ends of the sampler.
// Depends on tvs_pkg for the default depth.
module tvs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tvs_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import tvs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/tvs_front.sv -----
// Front end of the sampler: accepts items, holds the dimension registers,
// drops out-of-range writes and splits sample positions. Depends on tvs_pkg.
module tvs_front #(
  parameter int MAX_DIM    = tvs_pkg::MAX_DIM_DEF,
  parameter int VOXEL_BITS = tvs_pkg::VOXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic [tvs_pkg::INDEX_W-1:0]           in_voxel_index,
  input  logic [tvs_pkg::VALUE_W-1:0]           in_voxel_value,
  input  logic [tvs_pkg::POS_W-1:0]             in_pos_x,
  input  logic [tvs_pkg::POS_W-1:0]             in_pos_y,
  input  logic [tvs_pkg::POS_W-1:0]             in_pos_z,
  input  logic                                  cfg_we,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tvs_pkg::CFG_W-1:0]             cfg_wdata,
  output logic [tvs_pkg::CFG_W-1:0]             dim_x_eff,
  output logic [tvs_pkg::CFG_W-1:0]             dim_y_eff,
  output logic                                  q_push,
  output logic [tvs_pkg::cmd_width(MAX_DIM, VOXEL_BITS)-1:0] q_data,
  input  logic                                  q_full
);
  import tvs_pkg::*;

  localparam int ADDR_W      = addr_width(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;

  logic [CFG_W-1:0]   dim_x_r, dim_y_r, dim_z_r;
  logic [CFG_W-1:0]   dim_z_eff;
  logic               valid_r, valid_nxt;
  logic               op_r;
  logic [INDEX_W-1:0] index_r;
  logic [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]   pos_x_r, pos_y_r, pos_z_r;
  logic               accept, advance, keep;
  logic [AXIS_W-1:0]  split_x, split_y, split_z;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = CFG_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = CFG_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Scale a Q1.16 position by (dim - 1): floor index, ceil index, fraction
  function automatic logic [AXIS_W-1:0] axis_split(input logic [POS_W-1:0] pos,
                                                   input logic [CFG_W-1:0] dim);
    logic [POS_W-1:0]         p;
    logic [POS_W+CFG_W-1:0]   f;
    logic [IDX_W-1:0]         lo, hi;
    logic [FRAC_W-1:0]        t;
    p  = (pos > ONE_Q16) ? ONE_Q16 : pos;
    f  = (POS_W+CFG_W)'(p) * (POS_W+CFG_W)'(dim - CFG_W'(1));
    lo = f[FRAC_W +: IDX_W];
    t  = f[FRAC_W-1:0];
    hi = lo + IDX_W'(t != '0);
    return {lo, hi, t};
  endfunction

  assign dim_x_eff = eff_dim(dim_x_r);
  assign dim_y_eff = eff_dim(dim_y_r);
  assign dim_z_eff = eff_dim(dim_z_r);

  // Hold the item while the queue is full
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign advance  = valid_r && !q_full;
  assign keep     = (op_r == OP_SAMPLE) || (32'(index_r) < 32'(STORE_DEPTH));
  assign q_push   = advance && keep;

  assign split_x = axis_split(pos_x_r, dim_x_eff);
  assign split_y = axis_split(pos_y_r, dim_y_eff);
  assign split_z = axis_split(pos_z_r, dim_z_eff);

  assign q_data = {op_r == OP_SAMPLE, ADDR_W'(index_r), VOXEL_BITS'(value_r),
                   split_x, split_y, split_z};

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Dimension registers; writes beyond the last index do nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= DIM_RESET;
      dim_y_r <= DIM_RESET;
      dim_z_r <= DIM_RESET;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM_X: dim_x_r <= cfg_wdata;
          REG_DIM_Y: dim_y_r <= cfg_wdata;
          REG_DIM_Z: dim_z_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      index_r <= in_voxel_index;
      value_r <= in_voxel_value;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
    end
  end

endmodule

// ----- rtl/core/tvs_back.sv -----
// Back end of the sampler: owns the voxel memory, runs writes and the
// eight-read, seven-blend sample sequence, and holds the result. Depends on tvs_pkg.
module tvs_back #(
  parameter int MAX_DIM    = tvs_pkg::MAX_DIM_DEF,
  parameter int VOXEL_BITS = tvs_pkg::VOXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  logic [tvs_pkg::cmd_width(MAX_DIM, VOXEL_BITS)-1:0] q_data,
  output logic                                  q_pop,
  input  logic [tvs_pkg::CFG_W-1:0]             dim_x_eff,
  input  logic [tvs_pkg::CFG_W-1:0]             dim_y_eff,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tvs_pkg::OUT_W-1:0]             out_sample_value,
  output tvs_pkg::bk_stat_t                     bk_stat
);
  import tvs_pkg::*;

  localparam int ADDR_W = addr_width(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int VB     = VOXEL_BITS;
  localparam int PROD_W = VB + 18;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SAMPLE = 1'b1;

  // Sample sequence steps
  localparam logic [3:0] STEP_ROWS    = 4'd0;
  localparam logic [3:0] STEP_RD_FST  = 4'd1;
  localparam logic [3:0] STEP_RD_LST  = 4'd8;
  localparam logic [3:0] STEP_A_FST   = 4'd2;
  localparam logic [3:0] STEP_A_LST   = 4'd8;
  localparam logic [3:0] STEP_X_FST   = 4'd3;
  localparam logic [3:0] STEP_X_LST   = 4'd9;
  localparam logic [3:0] STEP_C_FST   = 4'd4;
  localparam logic [3:0] STEP_C_LST   = 4'd10;
  localparam logic [3:0] STEP_ZLO     = 4'd8;
  localparam logic [3:0] STEP_LOW     = 4'd9;
  localparam logic [3:0] STEP_ZHI     = 4'd11;
  localparam logic [3:0] STEP_HIGH    = 4'd12;
  localparam logic [3:0] STEP_Y       = 4'd13;
  localparam logic [3:0] STEP_DONE    = 4'd14;

  // Unpacked command
  logic               cmd_sample;
  logic [ADDR_W-1:0]  cmd_waddr;
  logic [VB-1:0]      cmd_wdata;
  logic [IDX_W-1:0]   cmd_x0, cmd_x1, cmd_y0, cmd_y1, cmd_z0, cmd_z1;
  logic [FRAC_W-1:0]  cmd_tx, cmd_ty, cmd_tz;

  logic               state_r, state_nxt;
  logic [3:0]         step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_value_r;

  logic [IDX_W-1:0]   x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [FRAC_W-1:0]  tx_r, ty_r, tz_r;
  logic [ROW_W-1:0]   row_r [4];
  logic [ROW_W-1:0]   z0dy, z1dy, rd_row;
  logic [2:0]         rd_k;
  logic [IDX_W-1:0]   rd_x;
  logic [LIN_W-1:0]   rd_lin;

  logic [VB-1:0]      mem [DEPTH];
  logic [VB-1:0]      rdata_r;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we, mem_re;

  logic [VB-1:0]      a_r, low_r, high_r;
  logic [VB-1:0]      c_r [4];
  logic [1:0]         c_idx;
  logic               busy, done;
  logic               rd_step, a_cap, x_step, c_cap, bl_load;

  logic [VB-1:0]            bl_a, bl_b, bl_res;
  logic [FRAC_W-1:0]        bl_t;
  logic signed [VB:0]       bl_diff;
  logic signed [PROD_W-1:0] bl_prod, bl_prod_r;
  logic [VB-1:0]            bl_a_r;
  logic [PROD_W-1:0]        bl_sum;

  assign {cmd_sample, cmd_waddr, cmd_wdata,
          cmd_x0, cmd_x1, cmd_tx, cmd_y0, cmd_y1, cmd_ty,
          cmd_z0, cmd_z1, cmd_tz} = q_data;

  assign busy    = (state_r == ST_SAMPLE);
  assign q_pop   = (state_r == ST_IDLE) && q_valid;
  assign done    = busy && (step_r == STEP_DONE) && (!out_valid_r || !out_stall);
  assign bk_stat = '{busy: busy, done: done};

  // Step decode
  assign rd_step = busy && (step_r >= STEP_RD_FST) && (step_r <= STEP_RD_LST);
  assign a_cap   = busy && (step_r >= STEP_A_FST) && (step_r <= STEP_A_LST) && !step_r[0];
  assign x_step  = busy && (step_r >= STEP_X_FST) && (step_r <= STEP_X_LST) && step_r[0];
  assign c_cap   = busy && (step_r >= STEP_C_FST) && (step_r <= STEP_C_LST) && !step_r[0];
  assign c_idx   = 2'((step_r - STEP_C_FST) >> 1);
  assign bl_load = x_step ||
                   (busy && ((step_r == STEP_ZLO) || (step_r == STEP_ZHI) ||
                             (step_r == STEP_Y)));

  // Row offsets y + z*dim_y for the four y/z corners
  assign z0dy = ROW_W'(z0_r) * ROW_W'(dim_y_eff);
  assign z1dy = ROW_W'(z1_r) * ROW_W'(dim_y_eff);

  // Read address: bit 0 picks x, bits 2:1 pick the y/z row
  assign rd_k   = 3'(step_r - STEP_RD_FST);
  assign rd_x   = rd_k[0] ? x1_r : x0_r;
  assign rd_row = row_r[rd_k[2:1]];
  assign rd_lin = LIN_W'(rd_row) * LIN_W'(dim_x_eff) + LIN_W'(rd_x);

  assign mem_we   = q_pop && !cmd_sample;
  assign mem_re   = rd_step;
  assign mem_addr = mem_we ? cmd_waddr : ADDR_W'(rd_lin);

  // Single-port voxel memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Pick the operands of the shared blend unit
  always_comb begin
    case (step_r)
      STEP_ZLO: begin
        bl_a = c_r[0];
        bl_b = c_r[1];
        bl_t = tz_r;
      end
      STEP_ZHI: begin
        bl_a = c_r[2];
        bl_b = c_r[3];
        bl_t = tz_r;
      end
      STEP_Y: begin
        bl_a = low_r;
        bl_b = high_r;
        bl_t = ty_r;
      end
      default: begin
        bl_a = a_r;
        bl_b = rdata_r;
        bl_t = tx_r;
      end
    endcase
  end

  // Blend: a + (b - a)*t, rounded; multiply here, add after the register
  assign bl_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
  assign bl_prod = PROD_W'(bl_diff) * PROD_W'($signed({1'b0, bl_t}));
  assign bl_sum  = {2'b00, bl_a_r, {FRAC_W{1'b0}}} + PROD_W'(bl_prod_r) +
                   PROD_W'(ROUND_HALF);
  assign bl_res  = bl_sum[FRAC_W +: VB];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_pop && cmd_sample) begin
          state_nxt = ST_SAMPLE;
          step_nxt  = STEP_ROWS;
        end
      end
      ST_SAMPLE: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (step_r != STEP_DONE) begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_ROWS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop && cmd_sample) begin
      x0_r <= cmd_x0;
      x1_r <= cmd_x1;
      tx_r <= cmd_tx;
      y0_r <= cmd_y0;
      y1_r <= cmd_y1;
      ty_r <= cmd_ty;
      z0_r <= cmd_z0;
      z1_r <= cmd_z1;
      tz_r <= cmd_tz;
    end
    if (busy && (step_r == STEP_ROWS)) begin
      row_r[0] <= ROW_W'(y0_r) + z0dy;
      row_r[1] <= ROW_W'(y0_r) + z1dy;
      row_r[2] <= ROW_W'(y1_r) + z0dy;
      row_r[3] <= ROW_W'(y1_r) + z1dy;
    end
    if (a_cap) begin
      a_r <= rdata_r;
    end
    if (bl_load) begin
      bl_a_r    <= bl_a;
      bl_prod_r <= bl_prod;
    end
    if (c_cap) begin
      c_r[c_idx] <= bl_res;
    end
    if (busy && (step_r == STEP_LOW)) begin
      low_r <= bl_res;
    end
    if (busy && (step_r == STEP_HIGH)) begin
      high_r <= bl_res;
    end
    if (done) begin
      out_value_r <= OUT_W'(bl_res);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule

// ----- tb/tb_trilinear_volume_sampler.sv -----
// Self-checking testbench for trilinear_volume_sampler: voxel writes, trilinear samples
// and dimension registers, checked against an in-bench fixed-point predictor.
// Depends on tvs_pkg and the RTL under rtl/core only.
module tb_trilinear_volume_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import tvs_pkg::*;

  localparam int                   CLK_HALF     = 4;
  localparam int                   RESET_CYCLES = 11;
  localparam int                   IDLE_SETTLE  = 40;
  localparam int                   QUIET_LIMIT  = 4000;
  localparam int                   STORE_SIZE   = 32768;
  localparam int                   PHASE_ITEMS  = 80;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(3);

  // Eight neighbour addresses, bit 0 = x high, bit 1 = z high, bit 2 = y high
  typedef struct packed {
    logic [7:0][INDEX_W-1:0] addr;
    logic [15:0]             tx;
    logic [15:0]             ty;
    logic [15:0]             tz;
  } corners_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_opcode;
  logic [INDEX_W-1:0]   in_voxel_index;
  logic [VALUE_W-1:0]   in_voxel_value;
  logic [POS_W-1:0]     in_pos_x;
  logic [POS_W-1:0]     in_pos_y;
  logic [POS_W-1:0]     in_pos_z;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_sample_value;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Predictor state: volume contents, which voxels hold data, dimension registers
  logic [VALUE_W-1:0] voxel_mem [STORE_SIZE];
  bit                 voxel_written [STORE_SIZE];
  logic [CFG_W-1:0]   dim_reg [3];
  logic [OUT_W-1:0]   expected_density [$];

  int errors = 0;
  int items_sent;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  trilinear_volume_sampler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_voxel_index   (in_voxel_index),
    .in_voxel_value   (in_voxel_value),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Map a dimension register to the size in use
  function automatic int eff_dim(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  function automatic int volume_size();
    return eff_dim(dim_reg[0]) * eff_dim(dim_reg[1]) * eff_dim(dim_reg[2]);
  endfunction

  // Round-to-nearest linear blend in Q0.16
  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] t,
                                        input logic [15:0] b);
    logic [39:0] acc;
    acc = 40'(a) * (40'd65536 - 40'(t)) + 40'(b) * 40'(t) + 40'(ROUND_HALF);
    return acc[31:16];
  endfunction

  // Split each coordinate into floor, ceil and fraction, then form the neighbour addresses
  function automatic corners_t locate(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                      input logic [POS_W-1:0] pz);
    corners_t          c;
    logic [POS_W-1:0]  p [3];
    logic [15:0]       fr [3];
    logic [31:0]       f;
    int                dim [3];
    int                lo [3];
    int                hi [3];
    int                x, y, z;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int a = 0; a < 3; a++) begin
      dim[a] = eff_dim(dim_reg[a]);
      if (p[a] > ONE_Q16) p[a] = ONE_Q16;
      f = 32'(p[a]) * 32'(dim[a] - 1);
      lo[a] = int'(f >> 16);
      fr[a] = f[15:0];
      hi[a] = lo[a] + ((fr[a] != 0) ? 1 : 0);
    end
    for (int i = 0; i < 8; i++) begin
      x = i[0] ? hi[0] : lo[0];
      z = i[1] ? hi[2] : lo[2];
      y = i[2] ? hi[1] : lo[1];
      c.addr[i] = INDEX_W'(x + (y + z * dim[1]) * dim[0]);
    end
    c.tx = fr[0];
    c.ty = fr[1];
    c.tz = fr[2];
    return c;
  endfunction

  // Blend along x, then z, then y
  function automatic logic [OUT_W-1:0] predict_density(input corners_t c);
    logic [15:0] xl [4];
    logic [15:0] low;
    logic [15:0] high;
    for (int j = 0; j < 4; j++)
      xl[j] = blend(voxel_mem[c.addr[2*j]], c.tx, voxel_mem[c.addr[2*j+1]]);
    low  = blend(xl[0], c.tz, xl[1]);
    high = blend(xl[2], c.tz, xl[3]);
    return blend(low, c.ty, high);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return ONE_Q16;
    if (r < 30) return POS_W'($urandom_range(131071, 65537));
    return POS_W'($urandom_range(65535));
  endfunction

  // Offer one item after a random gap, hold it until taken, then update the predictor
  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_voxel_index <= idx;
    in_voxel_value <= val;
    in_pos_x       <= px;
    in_pos_y       <= py;
    in_pos_z       <= pz;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == OP_WRITE) begin
      voxel_mem[idx]     = val;
      voxel_written[idx] = 1'b1;
    end else begin
      expected_density.push_back(predict_density(locate(px, py, pz)));
    end
  endtask

  // Fill any neighbour that holds no data yet, then sample
  task automatic sample_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [POS_W-1:0] pz);
    corners_t c;
    c = locate(px, py, pz);
    for (int i = 0; i < 8; i++)
      if (!voxel_written[c.addr[i]])
        send_item(OP_WRITE, c.addr[i], VALUE_W'($urandom), rand_pos(), rand_pos(), rand_pos());
    send_item(OP_SAMPLE, INDEX_W'($urandom), VALUE_W'($urandom), px, py, pz);
  endtask

  // Drop valid and wait until every sample has returned
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_density.size() != 0);
  endtask

  // Reprogram all dimension registers while the block is idle
  task automatic set_volume(input logic [CFG_W-1:0] nx, input logic [CFG_W-1:0] ny,
                            input logic [CFG_W-1:0] nz);
    hold_until_drained();
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIM_X;
    cfg_wdata <= nx;
    @(posedge clk);
    cfg_index <= REG_DIM_Y;
    cfg_wdata <= ny;
    @(posedge clk);
    cfg_index <= REG_DIM_Z;
    cfg_wdata <= nz;
    @(posedge clk);
    // Unused index must leave the dimensions alone
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we     <= 1'b0;
    dim_reg[0] = nx;
    dim_reg[1] = ny;
    dim_reg[2] = nz;
  endtask

  // Reset dimensions: first and last voxel of the full volume, saturated positions
  task automatic test_reset_volume();
    send_item(OP_WRITE, '0, '0, '0, '0, '0);
    send_item(OP_WRITE, '1, '1, '1, '1, '1);
    sample_point('0, '0, '0);
    sample_point(ONE_Q16, ONE_Q16, ONE_Q16);
    sample_point('1, '1, '1);
  endtask

  // Two-voxel cube: corners, center, tiny and large fractions, saturation per axis
  task automatic test_unit_cube();
    logic [15:0] corner_val [8];
    corner_val[0] = 16'h0000;
    corner_val[1] = 16'hFFFF;
    corner_val[2] = 16'h1234;
    corner_val[3] = 16'h8000;
    corner_val[4] = 16'h0001;
    corner_val[5] = 16'hFFFE;
    corner_val[6] = 16'h7FFF;
    corner_val[7] = 16'hAAAA;
    set_volume(CFG_W'(2), CFG_W'(2), CFG_W'(2));
    for (int i = 0; i < 8; i++)
      send_item(OP_WRITE, INDEX_W'(i), corner_val[i], '0, '0, '0);
    sample_point('0, '0, '0);
    sample_point(ONE_Q16, ONE_Q16, ONE_Q16);
    sample_point(POS_W'(32768), POS_W'(32768), POS_W'(32768));
    sample_point(POS_W'(1), POS_W'(1), POS_W'(1));
    sample_point(POS_W'(65535), '0, ONE_Q16);
    sample_point('1, '0, POS_W'(32768));
    sample_point('0, POS_W'(98304), POS_W'(49151));
  endtask

  // Zero dimension acts as one, oversized as the maximum, single-voxel volume
  task automatic test_dim_limits();
    set_volume(CFG_W'(0), CFG_W'(63), CFG_W'(1));
    repeat (3) sample_point(rand_pos(), rand_pos(), rand_pos());
    set_volume(CFG_W'(33), CFG_W'(0), CFG_W'(63));
    repeat (3) sample_point(rand_pos(), rand_pos(), rand_pos());
    set_volume(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    sample_point('1, POS_W'(32768), '0);
  endtask

  // Random phases: new dimensions and idle profile each phase, one drain pause per phase
  task automatic test_random_traffic();
    int          target;
    int          halfway;
    bit          held;
    logic [14:0] idx;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_volume(CFG_W'(32), CFG_W'(32), CFG_W'(32));
        1: set_volume(CFG_W'($urandom_range(32, 2)), CFG_W'($urandom_range(32, 2)),
                      CFG_W'($urandom_range(32, 2)));
        2: set_volume(CFG_W'(63), CFG_W'(2), CFG_W'(33));
        3: set_volume(CFG_W'(1), CFG_W'(32), CFG_W'(0));
        default: set_volume(CFG_W'($urandom_range(63)), CFG_W'($urandom_range(63)),
                            CFG_W'($urandom_range(63)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      target  = items_sent + PHASE_ITEMS;
      halfway = items_sent + PHASE_ITEMS / 2;
      held    = 1'b0;
      while (items_sent < target) begin
        if (!held && items_sent >= halfway) begin
          hold_until_drained();
          held = 1'b1;
        end
        if ($urandom_range(99) < 65) begin
          sample_point(rand_pos(), rand_pos(), rand_pos());
        end else begin
          // Overwrite inside the used volume half the time, anywhere in the store otherwise
          if ($urandom_range(1) == 0) idx = INDEX_W'($urandom_range(volume_size() - 1));
          else idx = INDEX_W'($urandom_range(STORE_SIZE - 1));
          send_item(OP_WRITE, idx, VALUE_W'($urandom), rand_pos(), rand_pos(), rand_pos());
        end
      end
    end
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Compare each taken result with the oldest pending sample
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_density.size() == 0) begin
        $error("sample_value: no sample pending, got %0d", out_sample_value);
        errors++;
      end else if (out_sample_value !== expected_density[0]) begin
        $error("sample_value: expected %0d, got %0d", expected_density[0], out_sample_value);
        errors++;
        void'(expected_density.pop_front());
      end else begin
        void'(expected_density.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    items_sent     = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    dim_reg[0]     = DIM_RESET;
    dim_reg[1]     = DIM_RESET;
    dim_reg[2]     = DIM_RESET;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_WRITE;
    in_voxel_index <= '0;
    in_voxel_value <= '0;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    in_pos_z       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_DIM_X;
    cfg_wdata      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_volume();
    test_unit_cube();
    test_dim_limits();
    test_random_traffic();

    hold_until_drained();
    repeat (IDLE_SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tvs_pkg.sv
rtl/core/tvs_queue.sv
rtl/core/tvs_front.sv
rtl/core/tvs_back.sv
rtl/core/trilinear_volume_sampler.sv
tb/tb_trilinear_volume_sampler.sv
